### rtl/skf_pkg.sv
// Shared types, constants and saturation helper for the scalar Kalman filter.
// No dependencies; used by skf_mul, skf_div and scalar_kalman_filter_unit.
package skf_pkg;

	localparam int DATA_W        = 32;
	localparam int DIGIT_W       = 4;
	localparam int FRAC_BITS_DEF = 16;
	localparam int CFG_ADDR_W    = 4;

	// register index codes, taken from paddr[3:2]
	localparam logic [1:0] REG_STATE_GAIN = 2'd0;
	localparam logic [1:0] REG_OBS_GAIN   = 2'd1;
	localparam logic [1:0] REG_PROC_NOISE = 2'd2;
	localparam logic [1:0] REG_MEAS_NOISE = 2'd3;

	typedef logic signed [DATA_W-1:0] word_t;

	localparam word_t S32_MAX = word_t'(32'h7FFF_FFFF);
	localparam word_t S32_MIN = word_t'(32'h8000_0000);

	// request to a serial arithmetic unit
	typedef struct packed {
		logic  start;
		word_t a;
		word_t b;
	} op_req_t;

	// Turn sign and magnitude into a saturated signed word.
	// hi_nz flags any magnitude bit at or above DATA_W.
	function automatic word_t sat_mag(input logic neg, input logic hi_nz,
			input logic [DATA_W-1:0] lo);
		word_t r;
		if (!neg) begin
			r = (hi_nz || lo[DATA_W-1]) ? S32_MAX : word_t'(lo);
		end else begin
			r = (hi_nz || (lo[DATA_W-1] && (|lo[DATA_W-2:0]))) ? S32_MIN
				: word_t'(~lo + 1'b1);
		end
		return r;
	endfunction

endpackage

### rtl/scalar_kalman_filter_unit.sv
// Top level of the scalar Kalman filter: register port, stream ports and the
// sequencer that drives skf_mul and skf_div. Depends on skf_pkg.
//
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  measurement (s_tdata[31:0])
// m_*       out  m_tvalid/m_tready  estimate [31:0], gain [63:32]
// apb       in   psel/penable       four registers at byte offsets 0,4,8,12
//
// One sample runs nine products through the shared 4-bit digit multiplier,
// plus the part of the 32 + FRAC_BITS step divide not hidden behind one product.
// Reset clears the registers to their defaults, estimate to 0, variance to 10.0.
// A result waits in the output register; the next sample is taken meanwhile,
// and the block stalls only when a new result finds that register still full.
module scalar_kalman_filter_unit #(
	parameter int FRAC_BITS = skf_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [skf_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [skf_pkg::DATA_W-1:0]       pwdata,
	output logic [skf_pkg::DATA_W-1:0]       prdata,
	output logic                             pready,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [skf_pkg::DATA_W-1:0]       s_tdata,  // [31:0] measurement
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [2*skf_pkg::DATA_W-1:0]     m_tdata   // [31:0] estimate, [63:32] gain
);

	localparam int DW = skf_pkg::DATA_W;

	localparam logic [63:0] ONE_W   = 64'd1 << FRAC_BITS;
	localparam logic [63:0] P_RST_W = 64'd10 << FRAC_BITS;
	localparam logic [63:0] Q_RST_W = (64'd655 << FRAC_BITS) >> 16;

	localparam skf_pkg::word_t ONE   = skf_pkg::word_t'(ONE_W[DW-1:0]);
	localparam skf_pkg::word_t P_RST = skf_pkg::word_t'(P_RST_W[DW-1:0]);
	localparam logic [DW-2:0]  Q_RST = Q_RST_W[DW-2:0];

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_MUL_GO   = 3'd1;
	localparam logic [2:0] ST_MUL_WAIT = 3'd2;
	localparam logic [2:0] ST_DIV_WAIT = 3'd3;
	localparam logic [2:0] ST_OUT      = 3'd4;

	localparam logic [3:0] OP_XP  = 4'd0;
	localparam logic [3:0] OP_AA  = 4'd1;
	localparam logic [3:0] OP_PP  = 4'd2;
	localparam logic [3:0] OP_NUM = 4'd3;
	localparam logic [3:0] OP_DEN = 4'd4;
	localparam logic [3:0] OP_HX  = 4'd5;
	localparam logic [3:0] OP_UPD = 4'd6;
	localparam logic [3:0] OP_KH  = 4'd7;
	localparam logic [3:0] OP_PN  = 4'd8;

	function automatic skf_pkg::word_t sat_add(input skf_pkg::word_t a,
			input skf_pkg::word_t b, input logic sub);
		logic [DW:0] s;
		s = sub ? ({a[DW-1], a} - {b[DW-1], b}) : ({a[DW-1], a} + {b[DW-1], b});
		if (s[DW] != s[DW-1]) begin
			return s[DW] ? skf_pkg::S32_MIN : skf_pkg::S32_MAX;
		end
		return skf_pkg::word_t'(s[DW-1:0]);
	endfunction

	// configuration and filter state
	skf_pkg::word_t a_q;
	skf_pkg::word_t h_q;
	logic [DW-2:0]  q_q;
	logic [DW-2:0]  r_q;
	skf_pkg::word_t x_q;
	skf_pkg::word_t p_q;

	// per-sample working registers
	skf_pkg::word_t z_q;
	skf_pkg::word_t xp_q;
	skf_pkg::word_t t_q;
	skf_pkg::word_t pp_q;
	skf_pkg::word_t num_q;
	skf_pkg::word_t innov_q;
	skf_pkg::word_t k_q;
	skf_pkg::word_t xn_q;
	skf_pkg::word_t s_q;

	logic [2:0]        state_q;
	logic [3:0]        op_q;
	logic              m_tvalid_q;
	logic [2*DW-1:0]   m_tdata_q;

	skf_pkg::op_req_t mul_req;
	skf_pkg::op_req_t div_req;
	logic             mul_done;
	skf_pkg::word_t   mul_res;
	logic             div_busy;
	skf_pkg::word_t   div_res;

	logic             cfg_wr;
	logic             in_beat;
	logic             mul_fin;
	logic             out_free;
	logic             out_load;
	skf_pkg::word_t   den_val;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite;
	assign s_tready = (state_q == ST_IDLE);
	assign in_beat  = s_tvalid && s_tready;
	assign mul_fin  = (state_q == ST_MUL_WAIT) && mul_done;
	assign out_free = !m_tvalid_q || m_tready;
	assign out_load = (state_q == ST_OUT) && out_free;
	assign den_val  = sat_add(mul_res, skf_pkg::word_t'({1'b0, r_q}), 1'b0);

	always_comb begin
		case (paddr[3:2])
			skf_pkg::REG_STATE_GAIN: prdata = a_q;
			skf_pkg::REG_OBS_GAIN:   prdata = h_q;
			skf_pkg::REG_PROC_NOISE: prdata = {1'b0, q_q};
			skf_pkg::REG_MEAS_NOISE: prdata = {1'b0, r_q};
			default:                 prdata = '0;
		endcase
	end

	// operand select for the shared multiplier
	always_comb begin
		mul_req.start = (state_q == ST_MUL_GO);
		case (op_q)
			OP_XP:   begin mul_req.a = a_q;     mul_req.b = x_q;  end
			OP_AA:   begin mul_req.a = a_q;     mul_req.b = a_q;  end
			OP_PP:   begin mul_req.a = t_q;     mul_req.b = p_q;  end
			OP_NUM:  begin mul_req.a = pp_q;    mul_req.b = h_q;  end
			OP_DEN:  begin mul_req.a = num_q;   mul_req.b = h_q;  end
			OP_HX:   begin mul_req.a = h_q;     mul_req.b = xp_q; end
			OP_UPD:  begin mul_req.a = innov_q; mul_req.b = k_q;  end
			OP_KH:   begin mul_req.a = k_q;     mul_req.b = h_q;  end
			OP_PN:   begin mul_req.a = s_q;     mul_req.b = pp_q; end
			default: begin mul_req.a = a_q;     mul_req.b = a_q;  end
		endcase
	end

	// launch the divide as soon as the denominator is known
	assign div_req.start = mul_fin && (op_q == OP_DEN);
	assign div_req.a     = num_q;
	assign div_req.b     = den_val;

	skf_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.done   (mul_done),
		.res    (mul_res)
	);

	skf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.busy   (div_busy),
		.res    (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q        <= ONE;
			h_q        <= ONE;
			q_q        <= Q_RST;
			r_q        <= ONE[DW-2:0];
			x_q        <= '0;
			p_q        <= P_RST;
			state_q    <= ST_IDLE;
			op_q       <= OP_XP;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				case (paddr[3:2])
					skf_pkg::REG_STATE_GAIN: a_q <= pwdata;
					skf_pkg::REG_OBS_GAIN:   h_q <= pwdata;
					skf_pkg::REG_PROC_NOISE: q_q <= pwdata[DW-2:0];
					skf_pkg::REG_MEAS_NOISE: r_q <= pwdata[DW-2:0];
					default:                 a_q <= a_q;
				endcase
			end

			m_tvalid_q <= out_load || (m_tvalid_q && !m_tready);

			case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						op_q    <= OP_XP;
						state_q <= ST_MUL_GO;
					end
				end
				ST_MUL_GO: state_q <= ST_MUL_WAIT;
				ST_MUL_WAIT: begin
					if (mul_done) begin
						case (op_q)
							OP_HX: state_q <= ST_DIV_WAIT;
							OP_PN: begin
								// commit the new state
								x_q     <= xn_q;
								p_q     <= mul_res;
								state_q <= ST_OUT;
							end
							default: begin
								op_q    <= op_q + 1'b1;
								state_q <= ST_MUL_GO;
							end
						endcase
					end
				end
				ST_DIV_WAIT: begin
					if (!div_busy) begin
						op_q    <= OP_UPD;
						state_q <= ST_MUL_GO;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			z_q <= s_tdata;
		end
		if (mul_fin) begin
			case (op_q)
				OP_XP:   xp_q    <= mul_res;
				OP_AA:   t_q     <= mul_res;
				OP_PP:   pp_q    <= sat_add(mul_res, skf_pkg::word_t'({1'b0, q_q}), 1'b0);
				OP_NUM:  num_q   <= mul_res;
				OP_HX:   innov_q <= sat_add(z_q, mul_res, 1'b1);
				OP_UPD:  xn_q    <= sat_add(xp_q, mul_res, 1'b0);
				OP_KH:   s_q     <= sat_add(ONE, mul_res, 1'b1);
				default: t_q     <= t_q;
			endcase
		end
		if (state_q == ST_DIV_WAIT && !div_busy) begin
			k_q <= div_res;
		end
		if (out_load) begin
			m_tdata_q <= {k_q, xn_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_mul_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == ST_MUL_WAIT))
		else $error("multiplier result arrived outside a wait");

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_busy)
		else $error("divide launched while the divider is busy");

	a_out_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |-> !div_busy)
		else $error("result formed before the gain was ready");

	a_accept_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> (state_q == ST_MUL_GO) && (op_q == OP_XP) && !div_busy)
		else $error("sample accepted with work still in flight");

endmodule

### rtl/skf_mul.sv
// Digit-serial signed fixed-point multiplier: one DIGIT_W digit of the
// multiplier per cycle, then floor shift by FRAC_BITS and saturation.
// Depends on skf_pkg.
module skf_mul #(
	parameter int FRAC_BITS = skf_pkg::FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  skf_pkg::op_req_t req,
	output logic             done,
	output skf_pkg::word_t   res
);

	localparam int DW    = skf_pkg::DATA_W;
	localparam int DIG   = skf_pkg::DIGIT_W;
	localparam int STEPS = DW / DIG;
	localparam int CNT_W = $clog2(STEPS);
	localparam int MW    = 2 * DW - FRAC_BITS;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_RUN  = 2'd1;
	localparam logic [1:0] PH_RND  = 2'd2;
	localparam logic [1:0] PH_SAT  = 2'd3;

	logic [1:0]       phase_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic             neg_q;
	logic [DW-1:0]    mag_a_q;
	logic [2*DW-1:0]  prod_q;
	logic [MW-1:0]    mag_q;
	skf_pkg::word_t   res_q;

	logic [DW-1:0]     a_abs;
	logic [DW-1:0]     b_abs;
	logic [DW+DIG-1:0] part_sum;
	logic [2*DW-1:0]   shifted;
	logic              low_nz;
	logic [MW-1:0]     mag_next;

	assign a_abs = req.a[DW-1] ? (~req.a + 1'b1) : req.a;
	assign b_abs = req.b[DW-1] ? (~req.b + 1'b1) : req.b;

	// upper half plus multiplicand times the lowest digit
	assign part_sum = {{DIG{1'b0}}, prod_q[2*DW-1:DW]}
		+ ({{DIG{1'b0}}, mag_a_q} * {{DW{1'b0}}, prod_q[DIG-1:0]});

	// floor on negative values: round the magnitude up when bits drop out
	assign shifted  = prod_q >> FRAC_BITS;
	assign low_nz   = |prod_q[FRAC_BITS-1:0];
	assign mag_next = shifted[MW-1:0] + {{(MW-1){1'b0}}, neg_q & low_nz};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (phase_q == PH_SAT);
			case (phase_q)
				PH_IDLE: begin
					if (req.start) begin
						cnt_q   <= '0;
						phase_q <= PH_RUN;
					end
				end
				PH_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(STEPS - 1)) begin
						phase_q <= PH_RND;
					end
				end
				PH_RND:  phase_q <= PH_SAT;
				PH_SAT:  phase_q <= PH_IDLE;
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (phase_q == PH_IDLE && req.start) begin
			neg_q   <= req.a[DW-1] ^ req.b[DW-1];
			mag_a_q <= a_abs;
			prod_q  <= {{DW{1'b0}}, b_abs};
		end
		if (phase_q == PH_RUN) begin
			prod_q <= {part_sum, prod_q[DW-1:DIG]};
		end
		if (phase_q == PH_RND) begin
			mag_q <= mag_next;
		end
		if (phase_q == PH_SAT) begin
			res_q <= skf_pkg::sat_mag(neg_q, |mag_q[MW-1:DW], mag_q[DW-1:0]);
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

### rtl/skf_div.sv
// Bit-serial restoring divider: (a * 2^FRAC_BITS) / b truncated toward zero,
// saturated to 32 bits, zero for a zero divisor. Depends on skf_pkg.
module skf_div #(
	parameter int FRAC_BITS = skf_pkg::FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  skf_pkg::op_req_t req,
	output logic             busy,
	output skf_pkg::word_t   res
);

	localparam int DW    = skf_pkg::DATA_W;
	localparam int NB    = DW + FRAC_BITS;
	localparam int CNT_W = $clog2(NB);

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_RUN  = 2'd1;
	localparam logic [1:0] PH_SAT  = 2'd2;

	logic [1:0]       phase_q;
	logic [CNT_W-1:0] cnt_q;
	logic             neg_q;
	logic [DW-1:0]    d_q;
	logic [DW-1:0]    rem_q;
	logic [NB-1:0]    dvd_q;
	skf_pkg::word_t   res_q;

	logic [DW-1:0] num_abs;
	logic [DW-1:0] den_abs;
	logic          den_zero;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          ge;

	assign num_abs  = req.a[DW-1] ? (~req.a + 1'b1) : req.a;
	assign den_abs  = req.b[DW-1] ? (~req.b + 1'b1) : req.b;
	assign den_zero = (req.b == '0);

	assign trial = {rem_q, dvd_q[NB-1]};
	assign ge    = (trial >= {1'b0, d_q});
	assign diff  = trial - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
		end else begin
			case (phase_q)
				PH_IDLE: begin
					if (req.start && !den_zero) begin
						cnt_q   <= '0;
						phase_q <= PH_RUN;
					end
				end
				PH_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(NB - 1)) begin
						phase_q <= PH_SAT;
					end
				end
				PH_SAT:  phase_q <= PH_IDLE;
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (phase_q == PH_IDLE && req.start) begin
			neg_q <= req.a[DW-1] ^ req.b[DW-1];
			d_q   <= den_abs;
			rem_q <= '0;
			dvd_q <= {num_abs, {FRAC_BITS{1'b0}}};
			if (den_zero) begin
				res_q <= '0;
			end
		end
		if (phase_q == PH_RUN) begin
			// shift quotient bits in as dividend bits leave
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
			dvd_q <= {dvd_q[NB-2:0], ge};
		end
		if (phase_q == PH_SAT) begin
			res_q <= skf_pkg::sat_mag(neg_q, |dvd_q[NB-1:DW], dvd_q[DW-1:0]);
		end
	end

	assign busy = (phase_q != PH_IDLE);
	assign res  = res_q;

endmodule

### dv/scalar_kalman_filter_unit_tb.sv
// Self-checking testbench for scalar_kalman_filter_unit: APB register setup, stream
// measurements in, estimate/gain beats out, checked against a Q16.16 filter predictor.
// Depends on skf_pkg and the RTL of the filter unit.
module scalar_kalman_filter_unit_tb;

	localparam int     FRAC       = skf_pkg::FRAC_BITS_DEF;
	localparam longint ONE_Q      = longint'(1) << FRAC;
	localparam int     IDLE_PCT   = 26;
	localparam int     ITEM_GOAL  = 1750;
	localparam int     DRAIN_WAIT = 200;
	localparam longint CYCLE_CAP  = 3_000_000;

	typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t       kind;
		logic [1:0]      reg_idx;
		logic [31:0]     value;
		bit              typed;
		skf_pkg::word_t  est;
		skf_pkg::word_t  gain;
	} stim_row_t;

	typedef struct {
		skf_pkg::word_t est;
		skf_pkg::word_t gain;
	} est_gain_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [skf_pkg::CFG_ADDR_W-1:0] paddr = '0;
	logic [skf_pkg::DATA_W-1:0]     pwdata = '0;
	logic [skf_pkg::DATA_W-1:0]     prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [skf_pkg::DATA_W-1:0]     s_tdata = '0;   // [31:0] measurement
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [2*skf_pkg::DATA_W-1:0]   m_tdata;        // [31:0] estimate, [63:32] gain

	// filter predictor state and registers
	longint cfg_a, cfg_h, cfg_q, cfg_r;
	longint est_q, var_q;

	est_gain_t pending_est[$];
	stim_row_t dir_rows[$];
	int        mismatches = 0;
	int        samples_sent = 0;
	longint    cycles = 0;
	bit        steady = 1'b0;
	int        track_center = 0;

	scalar_kalman_filter_unit uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic longint clamp32(longint v);
		if (v > longint'(skf_pkg::S32_MAX)) return longint'(skf_pkg::S32_MAX);
		if (v < longint'(skf_pkg::S32_MIN)) return longint'(skf_pkg::S32_MIN);
		return v;
	endfunction

	// product floored to FRAC fraction bits
	function automatic longint qmul(longint a, longint b);
		return clamp32((a * b) >>> FRAC);
	endfunction

	function automatic longint qdiv(longint num, longint den);
		if (den == 0) return 0;
		return clamp32((num <<< FRAC) / den);
	endfunction

	function automatic est_gain_t kalman_step(skf_pkg::word_t z);
		longint xp, pp, num, den, k, innov, xn, pn;
		est_gain_t r;
		xp = qmul(cfg_a, est_q);
		pp = clamp32(qmul(qmul(cfg_a, cfg_a), var_q) + cfg_q);
		num = qmul(pp, cfg_h);
		den = clamp32(qmul(num, cfg_h) + cfg_r);
		k = qdiv(num, den);
		innov = clamp32(longint'(z) - qmul(cfg_h, xp));
		xn = clamp32(xp + qmul(innov, k));
		pn = qmul(clamp32(ONE_Q - qmul(k, cfg_h)), pp);
		est_q = xn;
		var_q = pn;
		r.est = skf_pkg::word_t'(xn);
		r.gain = skf_pkg::word_t'(k);
		return r;
	endfunction

	task automatic report(string what, skf_pkg::word_t got, skf_pkg::word_t want);
		mismatches++;
		$display("MISMATCH %s: got %h, want %h (cycle %0d)", what, got, want, cycles);
	endtask

	// result checker
	always @(posedge clk) begin
		est_gain_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_est.size() == 0) begin
				report("beat with nothing pending", skf_pkg::word_t'(m_tdata[31:0]), '0);
			end else begin
				want = pending_est.pop_front();
				if (skf_pkg::word_t'(m_tdata[31:0]) !== want.est)
					report("estimate", skf_pkg::word_t'(m_tdata[31:0]), want.est);
				if (skf_pkg::word_t'(m_tdata[63:32]) !== want.gain)
					report("gain", skf_pkg::word_t'(m_tdata[63:32]), want.gain);
			end
		end
	end

	// receiver backpressure
	always @(negedge clk) begin
		m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
	end

	task automatic send_sample(skf_pkg::word_t z, bit typed, est_gain_t typed_res);
		est_gain_t res;
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= z;
		do @(posedge clk); while (!s_tready);
		res = kalman_step(z);
		pending_est.push_back(typed ? typed_res : res);
		samples_sent++;
		@(negedge clk);
	endtask

	// hold off until every pending result has left the block
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_est.size() != 0) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			skf_pkg::REG_STATE_GAIN: cfg_a = longint'(skf_pkg::word_t'(v));
			skf_pkg::REG_OBS_GAIN:   cfg_h = longint'(skf_pkg::word_t'(v));
			skf_pkg::REG_PROC_NOISE: cfg_q = longint'({1'b0, v[30:0]});
			skf_pkg::REG_MEAS_NOISE: cfg_r = longint'({1'b0, v[30:0]});
			default: ;
		endcase
		// idle bus cycle between transfers
		@(negedge clk);
	endtask

	function automatic void row(row_kind_t k, logic [1:0] idx, logic [31:0] v,
			bit typed = 1'b0, skf_pkg::word_t e = '0, skf_pkg::word_t g = '0);
		stim_row_t r;
		r.kind = k;
		r.reg_idx = idx;
		r.value = v;
		r.typed = typed;
		r.est = e;
		r.gain = g;
		dir_rows.push_back(r);
	endfunction

	function automatic logic [31:0] pick_factor();
		logic [31:0] v;
		case ($urandom_range(11))
			0: v = 32'h7FFF_FFFF;
			1: v = 32'h8000_0000;
			2: v = 32'h0000_0000;
			3: v = $urandom;
			4: v = 32'hFFFF_0000;
			default: begin
				v = $urandom_range(32768, 98304);
				if ($urandom_range(9) == 0) v = -v;
			end
		endcase
		return v;
	endfunction

	function automatic logic [31:0] pick_variance();
		case ($urandom_range(7))
			0: return 32'h0000_0000;
			1: return 32'h7FFF_FFFF;
			2: return $urandom & 32'h7FFF_FFFF;
			default: return $urandom_range(0, 1 << 17);
		endcase
	endfunction

	function automatic skf_pkg::word_t pick_measurement();
		case ($urandom_range(19))
			0: return skf_pkg::S32_MAX;
			1: return skf_pkg::S32_MIN;
			2, 3, 4: return skf_pkg::word_t'($urandom);
			5: return skf_pkg::word_t'($urandom_range(0, 255)) - 128;
			default: return skf_pkg::word_t'(track_center
				+ int'($urandom_range(0, 8 << 16)) - (4 << 16));
		endcase
	endfunction

	initial begin
		est_gain_t typed_res;
		stim_row_t r;
		int phase, phase_len;

		cfg_a = ONE_Q;
		cfg_h = ONE_Q;
		cfg_q = 655;
		cfg_r = ONE_Q;
		est_q = 0;
		var_q = longint'(10) << FRAC;

		// after reset: zero estimate, variance 10.0
		row(ROW_SAMPLE, '0, 32'h0000_0000, 1'b1, 32'sd0, 32'sd59583);
		row(ROW_SAMPLE, '0, 32'h7FFF_FFFF);
		row(ROW_SAMPLE, '0, 32'h8000_0000);
		row(ROW_SAMPLE, '0, 32'hFFFF_FFFF);
		row(ROW_SAMPLE, '0, 32'h0001_0000);
		// all registers at their extremes
		row(ROW_WRITE, skf_pkg::REG_STATE_GAIN, 32'h7FFF_FFFF);
		row(ROW_WRITE, skf_pkg::REG_OBS_GAIN,   32'h8000_0000);
		row(ROW_WRITE, skf_pkg::REG_PROC_NOISE, 32'h7FFF_FFFF);
		row(ROW_WRITE, skf_pkg::REG_MEAS_NOISE, 32'h7FFF_FFFF);
		row(ROW_SAMPLE, '0, 32'h7FFF_FFFF);
		row(ROW_SAMPLE, '0, 32'h8000_0000);
		row(ROW_WRITE, skf_pkg::REG_STATE_GAIN, 32'h8000_0000);
		row(ROW_WRITE, skf_pkg::REG_OBS_GAIN,   32'h7FFF_FFFF);
		row(ROW_WRITE, skf_pkg::REG_PROC_NOISE, 32'h0000_0000);
		row(ROW_WRITE, skf_pkg::REG_MEAS_NOISE, 32'h0000_0000);
		row(ROW_SAMPLE, '0, 32'h0000_0001);
		row(ROW_SAMPLE, '0, 32'h8000_0000);
		// zero denominator: gain 0, estimate held at A*x = 0
		row(ROW_WRITE, skf_pkg::REG_STATE_GAIN, 32'h0000_0000);
		row(ROW_WRITE, skf_pkg::REG_OBS_GAIN,   32'h0000_0000);
		row(ROW_SAMPLE, '0, 32'h0001_2345, 1'b1, 32'sd0, 32'sd0);
		// huge H saturates the denominator, K*H > 1, variance goes negative
		row(ROW_WRITE, skf_pkg::REG_STATE_GAIN, 32'h0001_0000);
		row(ROW_WRITE, skf_pkg::REG_OBS_GAIN,   32'h1000_0000);
		row(ROW_WRITE, skf_pkg::REG_PROC_NOISE, 32'h0000_028F);
		row(ROW_WRITE, skf_pkg::REG_MEAS_NOISE, 32'h0001_0000);
		row(ROW_SAMPLE, '0, 32'h0005_0000);
		row(ROW_SAMPLE, '0, 32'hFFFB_0000);
		row(ROW_SAMPLE, '0, 32'h0003_0000);
		// small H, negative A
		row(ROW_WRITE, skf_pkg::REG_OBS_GAIN,   32'h0000_8000);
		row(ROW_WRITE, skf_pkg::REG_STATE_GAIN, 32'hFFFF_0000);
		row(ROW_SAMPLE, '0, 32'h0002_0000);
		row(ROW_SAMPLE, '0, 32'hFFFE_8000);

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			r = dir_rows[i];
			if (r.kind == ROW_WRITE) begin
				drain();
				write_reg(r.reg_idx, r.value);
			end else begin
				typed_res.est = r.est;
				typed_res.gain = r.gain;
				send_sample(skf_pkg::word_t'(r.value), r.typed, typed_res);
			end
		end

		phase = 0;
		while (samples_sent < ITEM_GOAL) begin
			drain();
			if (phase == 0) begin
				// nominal defaults first
				write_reg(skf_pkg::REG_STATE_GAIN, 32'h0001_0000);
				write_reg(skf_pkg::REG_OBS_GAIN,   32'h0001_0000);
				write_reg(skf_pkg::REG_PROC_NOISE, 32'h0000_028F);
				write_reg(skf_pkg::REG_MEAS_NOISE, 32'h0001_0000);
			end else begin
				write_reg(skf_pkg::REG_STATE_GAIN, pick_factor());
				write_reg(skf_pkg::REG_OBS_GAIN,   pick_factor());
				write_reg(skf_pkg::REG_PROC_NOISE, pick_variance());
				write_reg(skf_pkg::REG_MEAS_NOISE, pick_variance());
			end
			steady = (phase == 2);
			track_center = int'($urandom_range(0, 2000 << 16)) - (1000 << 16);
			phase_len = $urandom_range(60, 180);
			if (phase_len > ITEM_GOAL - samples_sent) phase_len = ITEM_GOAL - samples_sent;
			repeat (phase_len) begin
				if ($urandom_range(39) == 0) drain();
				send_sample(pick_measurement(), 1'b0, typed_res);
			end
			phase++;
		end
		steady = 1'b0;

		drain();
		repeat (DRAIN_WAIT) @(negedge clk);
		if (mismatches == 0 && pending_est.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
